FILE: rtl/core/pfhd_pkg.sv
package pfhd_pkg;

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int HASH_W  = 32;
    localparam int IDX_W   = 5;
    localparam int CNT_W   = 6;
    localparam int MODE_W  = 2;
    localparam int POS_W   = 16;
    localparam int L3_W    = 8;
    localparam int TAG_W   = 3;
    localparam int MAC_W   = 11;
    localparam int CFG_IDX_W = 2;

    // Limits
    localparam int MAX_SLAVES    = 32;
    localparam int MAX_VLAN_TAGS = 4;

    // Ethertypes
    localparam logic [15:0] ETH_VLAN = 16'h8100;
    localparam logic [15:0] ETH_IPV4 = 16'h0800;
    localparam logic [15:0] ETH_IPV6 = 16'h86DD;

    // Layer-3 start offset of an untagged frame
    localparam logic [L3_W-1:0] L3_START_UNTAGGED = 8'd14;

    // Hash modes
    localparam logic [MODE_W-1:0] MODE_IP    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MAC   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PROTO = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HASH_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_COUNT = 2'd1;

    // Hash queue between parser and divider
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Remainder unit: four dividend bits per step
    localparam int DIV_BITS  = 4;
    localparam int DIV_STEPS = HASH_W / DIV_BITS;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        PH_ETHER  = 3'd0,
        PH_IPV4   = 3'd1,
        PH_IPV6   = 3'd2,
        PH_DONE   = 3'd3,
        PH_NOHASH = 3'd4
    } t_phase;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_DIV  = 1'b1
    } t_back_state;

    // One hash beat between parser, queue and divider
    typedef struct packed {
        logic              valid;
        logic [HASH_W-1:0] hash;
    } t_hash_beat;

endpackage

FILE: rtl/core/pfhd_front.sv
module pfhd_front
    import pfhd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [BYTE_W-1:0] i_frame_byte,
    input  logic              i_last_byte,
    input  logic [MODE_W-1:0] i_hash_mode,
    output t_hash_beat        o_push
);

    logic [POS_W-1:0]  r_pos,      n_pos;
    logic [BYTE_W-1:0] r_ether_hi, n_ether_hi;
    logic [L3_W-1:0]   r_l3,       n_l3;
    logic [TAG_W-1:0]  r_tags,     n_tags;
    logic [HASH_W-1:0] r_acc,      n_acc;
    logic [HASH_W-1:0] r_word,     n_word;
    t_phase            r_phase,    n_phase;
    logic [MAC_W-1:0]  r_mac,      n_mac;
    logic [BYTE_W-1:0] r_proto,    n_proto;

    logic [L3_W-1:0]   l3_m1, l3_m2;
    logic [POS_W-1:0]  rel;
    logic              in_l3;
    logic              mac_hit;
    logic [15:0]       kind;
    logic [HASH_W-1:0] wv4, wv6;
    logic [HASH_W-1:0] hash;

    // Per-byte header walk
    always_comb begin
        n_pos      = r_pos;
        n_ether_hi = r_ether_hi;
        n_l3       = r_l3;
        n_tags     = r_tags;
        n_acc      = r_acc;
        n_word     = r_word;
        n_phase    = r_phase;
        n_mac      = r_mac;
        n_proto    = r_proto;

        l3_m1   = r_l3 - 8'd1;
        l3_m2   = r_l3 - 8'd2;
        in_l3   = (r_pos >= {8'd0, r_l3});
        rel     = r_pos - {8'd0, r_l3};
        kind    = {r_ether_hi, i_frame_byte};
        wv4     = {r_word[23:0], i_frame_byte};
        wv6     = {i_frame_byte, r_word[31:8]};
        mac_hit = (r_pos == 16'd3) || (r_pos == 16'd4) || (r_pos == 16'd5) ||
                  (r_pos == 16'd9) || (r_pos == 16'd10) || (r_pos == 16'd11);

        if (mac_hit) begin
            n_mac = r_mac + {3'd0, i_frame_byte};
        end

        case (r_phase)
            PH_ETHER: begin
                if (r_pos == {8'd0, l3_m2}) begin
                    n_ether_hi = i_frame_byte;
                end else if (r_pos == {8'd0, l3_m1}) begin
                    if (kind == ETH_VLAN) begin
                        if (r_tags >= TAG_W'(MAX_VLAN_TAGS)) begin
                            n_phase = PH_NOHASH;
                        end else begin
                            n_tags = r_tags + 3'd1;
                            n_l3   = r_l3 + 8'd4;
                        end
                    end else if (kind == ETH_IPV4) begin
                        n_phase = PH_IPV4;
                    end else if (kind == ETH_IPV6) begin
                        n_phase = PH_IPV6;
                    end else begin
                        n_phase = PH_NOHASH;
                    end
                end
            end
            PH_IPV4: begin
                if (in_l3) begin
                    if (rel == 16'd9) n_proto = i_frame_byte;
                    if (rel >= 16'd12 && rel <= 16'd19) begin
                        if (rel[1:0] == 2'd3) begin
                            n_acc  = r_acc + wv4;
                            n_word = '0;
                        end else begin
                            n_word = wv4;
                        end
                    end
                    if (rel == 16'd19) n_phase = PH_DONE;
                end
            end
            PH_IPV6: begin
                if (in_l3) begin
                    if (rel == 16'd6) n_proto = i_frame_byte;
                    if (rel >= 16'd8 && rel <= 16'd39) begin
                        if (rel[1:0] == 2'd3) begin
                            n_acc  = r_acc + wv6;
                            n_word = '0;
                        end else begin
                            n_word = wv6;
                        end
                    end
                    if (rel == 16'd39) n_phase = PH_DONE;
                end
            end
            default: begin
            end
        endcase

        if (r_pos != 16'hFFFF) begin
            n_pos = r_pos + 16'd1;
        end

        // Hash select on the last byte, mode sampled here
        if (i_hash_mode == MODE_MAC) begin
            hash = {21'd0, n_mac};
        end else if (n_phase != PH_DONE) begin
            hash = '0;
        end else if (i_hash_mode == MODE_IP) begin
            hash = n_acc;
        end else begin
            hash = {24'd0, n_proto};
        end
    end

    assign o_push.valid = i_accept && i_last_byte;
    assign o_push.hash  = hash;

    // Frame state, cleared after each last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last_byte)) begin
            r_pos      <= '0;
            r_ether_hi <= '0;
            r_l3       <= L3_START_UNTAGGED;
            r_tags     <= '0;
            r_acc      <= '0;
            r_word     <= '0;
            r_phase    <= PH_ETHER;
            r_mac      <= '0;
            r_proto    <= '0;
        end else if (i_accept) begin
            r_pos      <= n_pos;
            r_ether_hi <= n_ether_hi;
            r_l3       <= n_l3;
            r_tags     <= n_tags;
            r_acc      <= n_acc;
            r_word     <= n_word;
            r_phase    <= n_phase;
            r_mac      <= n_mac;
            r_proto    <= n_proto;
        end
    end

endmodule

FILE: rtl/core/pfhd_queue.sv
module pfhd_queue
    import pfhd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_hash_beat i_push,
    input  logic       i_pop,
    output logic       o_full,
    output t_hash_beat o_head
);

    logic [HASH_W-1:0] r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QPTR_W:0]   r_count;
    logic              do_push, do_pop;

    assign o_full       = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.hash  = r_mem[r_rd];

    assign do_push = i_push.valid && !o_full;
    assign do_pop  = i_pop && o_head.valid;

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) r_wr <= QPTR_W'((r_wr + 1'b1) % QUEUE_DEPTH);
            if (do_pop)  r_rd <= QPTR_W'((r_rd + 1'b1) % QUEUE_DEPTH);
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_push.hash;
    end

endmodule

FILE: rtl/core/pfhd_back.sv
module pfhd_back
    import pfhd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_hash_beat        i_head,
    output logic              o_pop,
    input  logic [CNT_W-1:0]  i_slave_count,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [HASH_W-1:0] o_hash_value,
    output logic [IDX_W-1:0]  o_slave_index,
    output logic [HASH_W-1:0] o_slave_mask
);

    t_back_state       r_state, n_state;
    logic [STEP_W-1:0] r_step;
    logic [HASH_W-1:0] r_hash;
    logic [HASH_W-1:0] r_dvd;
    logic [CNT_W-1:0]  r_div;
    logic [CNT_W-1:0]  r_rem;
    logic              r_out_valid;

    logic [CNT_W-1:0]  n_rem;
    logic [CNT_W-1:0]  count_eff;
    logic              slot_free;
    logic              last_step;
    logic              load_out;

    // Restoring remainder over DIV_BITS dividend bits
    function automatic logic [CNT_W-1:0] mod_step(input logic [CNT_W-1:0] rem,
                                                  input logic [DIV_BITS-1:0] bits,
                                                  input logic [CNT_W-1:0] d);
        logic [CNT_W-1:0] r;
        r = rem;
        for (int i = DIV_BITS - 1; i >= 0; i--) begin
            r = {r[CNT_W-2:0], bits[i]};
            if (r >= d) r = r - d;
        end
        return r;
    endfunction

    // Clamp slave count to 1..MAX_SLAVES
    always_comb begin
        if (i_slave_count == '0) begin
            count_eff = CNT_W'(1);
        end else if (i_slave_count > CNT_W'(MAX_SLAVES)) begin
            count_eff = CNT_W'(MAX_SLAVES);
        end else begin
            count_eff = i_slave_count;
        end
    end

    assign n_rem     = mod_step(r_rem, r_dvd[HASH_W-1 -: DIV_BITS], r_div);
    assign slot_free = !r_out_valid || !i_stall;
    assign last_step = (r_step == STEP_W'(DIV_STEPS - 1));

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_pop    = 1'b0;
        load_out = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (i_head.valid) begin
                    o_pop   = 1'b1;
                    n_state = BK_DIV;
                end
            end
            BK_DIV: begin
                if (last_step && slot_free) begin
                    load_out = 1'b1;
                    n_state  = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    // Divider datapath; holds on the last step until the output slot frees
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_hash <= i_head.hash;
            r_dvd  <= i_head.hash;
            r_div  <= count_eff;
            r_rem  <= '0;
            r_step <= '0;
        end else if (r_state == BK_DIV && !last_step) begin
            r_dvd  <= r_dvd << DIV_BITS;
            r_rem  <= n_rem;
            r_step <= r_step + 1'b1;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            o_hash_value  <= r_hash;
            o_slave_index <= n_rem[IDX_W-1:0];
            o_slave_mask  <= HASH_W'(1) << n_rem[IDX_W-1:0];
        end
    end

    assign o_valid = r_out_valid;

endmodule

FILE: rtl/core/packet_flow_hash_distributor.sv
// Throughput: one frame byte per cycle while the hash queue is not full; the
// remainder unit (4 bits a step, 8 steps) finishes one frame before it pops
// the next, and a 2-deep hash queue absorbs shorter frames before the byte
// input stalls. Reset: synchronous, active low; clears parser state, queue,
// divider state and output valid, and sets hash_mode to 0 and slave_count to 1.
module packet_flow_hash_distributor
    import pfhd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [BYTE_W-1:0]    i_frame_byte,
    input  logic                 i_last_byte,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [HASH_W-1:0]    o_hash_value,
    output logic [IDX_W-1:0]     o_slave_index,
    output logic [HASH_W-1:0]    o_slave_mask,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CNT_W-1:0]     i_cfg_data
);

    logic [MODE_W-1:0] r_hash_mode;
    logic [CNT_W-1:0]  r_slave_count;
    t_hash_beat        push, head;
    logic              q_full, pop;
    logic              in_accept;

    // Config registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash_mode   <= MODE_IP;
            r_slave_count <= CNT_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_HASH_MODE) r_hash_mode <= i_cfg_data[MODE_W-1:0];
            if (i_cfg_index == CFG_SLAVE_COUNT) r_slave_count <= i_cfg_data;
        end
    end

    assign o_stall   = q_full;
    assign in_accept = i_valid && !o_stall;

    pfhd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_frame_byte (i_frame_byte),
        .i_last_byte  (i_last_byte),
        .i_hash_mode  (r_hash_mode),
        .o_push       (push)
    );

    pfhd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_head  (head)
    );

    pfhd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .o_pop         (pop),
        .i_slave_count (r_slave_count),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_hash_value  (o_hash_value),
        .o_slave_index (o_slave_index),
        .o_slave_mask  (o_slave_mask)
    );

endmodule

FILE: rtl/core/pfhd_checker.sv
module pfhd_checker
    import pfhd_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_valid,
    input logic              i_stall,
    input logic [HASH_W-1:0] o_hash_value,
    input logic [IDX_W-1:0]  o_slave_index,
    input logic [HASH_W-1:0] o_slave_mask
);

    // Mask is the one-hot of the index
    a_mask_matches_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_slave_mask == (HASH_W'(1) << o_slave_index)))
        else $error("slave_mask does not match slave_index");

    // A zero hash always goes to consumer 0
    a_zero_hash_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hash_value == '0) |-> (o_slave_index == '0))
        else $error("zero hash gave nonzero slave_index");

    // No result beat right out of reset
    a_reset_clears_valid: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_valid)
        else $error("result valid directly after reset");

    // Stalled result beat holds
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_hash_value)
                                  && $stable(o_slave_index)))
        else $error("stalled result beat changed");

endmodule

bind packet_flow_hash_distributor pfhd_checker u_pfhd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_hash_value  (o_hash_value),
    .o_slave_index (o_slave_index),
    .o_slave_mask  (o_slave_mask)
);

FILE: test/packet_flow_hash_distributor_test.sv
`timescale 1ns / 100ps

module packet_flow_hash_distributor_test;
    import pfhd_pkg::*;

    // Mode and register codes the package leaves unnamed
    localparam logic [MODE_W-1:0]    MODE_SPARE   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    localparam int LATENCY_PAD  = 16;
    localparam int RAND_BYTES   = 220;
    localparam int RAND_FRAMES  = 16;
    localparam int REPORT_LIMIT = 10;
    localparam int HOLD_CYCLES  = 150;

    typedef enum {FK_IPV4, FK_IPV6, FK_OTHER, FK_RAW} t_frame_kind;
    typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} t_fill;

    typedef struct packed {
        logic [HASH_W-1:0] hash;
        logic [IDX_W-1:0]  idx;
        logic [HASH_W-1:0] mask;
    } t_flow_result;

    // One directed frame: register settings, frame shape, optional fixed result
    typedef struct {
        logic [MODE_W-1:0] mode;
        logic [CNT_W-1:0]  count;
        t_frame_kind       kind;
        t_fill             fill;
        int                tags;
        int                cut;
        int                extra;
        bit                pinned;
        t_flow_result      want;
    } t_flow_case;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [BYTE_W-1:0]    i_frame_byte;
    logic                 i_last_byte;
    logic                 o_valid;
    logic                 i_stall;
    logic [HASH_W-1:0]    o_hash_value;
    logic [IDX_W-1:0]     o_slave_index;
    logic [HASH_W-1:0]    o_slave_mask;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CNT_W-1:0]     i_cfg_data;

    packet_flow_hash_distributor u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_frame_byte  (i_frame_byte),
        .i_last_byte   (i_last_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_hash_value  (o_hash_value),
        .o_slave_index (o_slave_index),
        .o_slave_mask  (o_slave_mask),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Parser shadow state
    logic [POS_W-1:0]  p_pos;
    logic [15:0]       p_type_word;
    logic [L3_W-1:0]   p_l3_at;
    logic [TAG_W-1:0]  p_tags;
    logic [HASH_W-1:0] p_addr_sum;
    logic [31:0]       p_word;
    t_phase            p_phase;
    logic [MAC_W-1:0]  p_mac_sum;
    logic [7:0]        p_proto;
    logic [MODE_W-1:0] cfg_mode   = MODE_IP;
    logic [CNT_W-1:0]  cfg_slaves = 6'd1;

    t_flow_result pending_flows[$];
    t_flow_result seen_flow;
    t_flow_result head_flow;
    t_flow_result pinned_flow;
    bit           pin_flow;
    logic [7:0]   frame_q[$];
    t_flow_case   dir_table[$];
    int           fault_count;
    int           burst_left;
    bit           steady_send;
    bit           hold_req;

    function automatic void clear_flow_state();
        p_pos       = '0;
        p_type_word = '0;
        p_l3_at     = L3_START_UNTAGGED;
        p_tags      = '0;
        p_addr_sum  = '0;
        p_word      = '0;
        p_phase     = PH_ETHER;
        p_mac_sum   = '0;
        p_proto     = '0;
    endfunction

    // Advance the shadow parser by one frame byte
    function automatic void parse_byte(input logic [7:0] b);
        logic [POS_W-1:0] rel;
        if (p_pos inside {3, 4, 5, 9, 10, 11})
            p_mac_sum += b;
        case (p_phase)
            PH_ETHER: begin
                if (p_pos == p_l3_at - 16'd2) begin
                    p_type_word = {b, 8'h00};
                end else if (p_pos == p_l3_at - 16'd1) begin
                    p_type_word[7:0] = b;
                    if (p_type_word == ETH_VLAN) begin
                        if (p_tags >= MAX_VLAN_TAGS) begin
                            p_phase = PH_NOHASH;
                        end else begin
                            p_tags  = p_tags + 3'd1;
                            p_l3_at = p_l3_at + 8'd4;
                        end
                    end else if (p_type_word == ETH_IPV4) begin
                        p_phase = PH_IPV4;
                    end else if (p_type_word == ETH_IPV6) begin
                        p_phase = PH_IPV6;
                    end else begin
                        p_phase = PH_NOHASH;
                    end
                end
            end
            PH_IPV4: begin
                if (p_pos >= p_l3_at) begin
                    rel = p_pos - p_l3_at;
                    if (rel == 16'd9)
                        p_proto = b;
                    // addresses are big-endian words
                    if (rel >= 16'd12 && rel <= 16'd19) begin
                        p_word = {p_word[23:0], b};
                        if (rel[1:0] == 2'd3) begin
                            p_addr_sum += p_word;
                            p_word = '0;
                        end
                    end
                    if (rel == 16'd19)
                        p_phase = PH_DONE;
                end
            end
            PH_IPV6: begin
                if (p_pos >= p_l3_at) begin
                    rel = p_pos - p_l3_at;
                    if (rel == 16'd6)
                        p_proto = b;
                    // addresses are read as little-endian words
                    if (rel >= 16'd8 && rel <= 16'd39) begin
                        p_word = {b, p_word[31:8]};
                        if (rel[1:0] == 2'd3) begin
                            p_addr_sum += p_word;
                            p_word = '0;
                        end
                    end
                    if (rel == 16'd39)
                        p_phase = PH_DONE;
                end
            end
            default: ;
        endcase
        if (p_pos != 16'hFFFF)
            p_pos = p_pos + 16'd1;
    endfunction

    // Hash, chosen consumer and mask for the frame that just ended
    function automatic t_flow_result flow_result_now();
        t_flow_result r;
        logic [CNT_W-1:0] n;
        if (cfg_mode == MODE_MAC)
            r.hash = {{(HASH_W-MAC_W){1'b0}}, p_mac_sum};
        else if (p_phase != PH_DONE)
            r.hash = '0;
        else if (cfg_mode == MODE_IP)
            r.hash = p_addr_sum;
        else
            r.hash = {24'h0, p_proto};
        if (cfg_slaves == 0)
            n = 6'd1;
        else if (cfg_slaves > MAX_SLAVES)
            n = 6'(MAX_SLAVES);
        else
            n = cfg_slaves;
        r.idx  = IDX_W'(r.hash % n);
        r.mask = 32'h1 << r.idx;
        return r;
    endfunction

    function automatic logic [7:0] fill_byte(input t_fill fill);
        case (fill)
            FILL_ZERO: return 8'h00;
            FILL_ONES: return 8'hFF;
            default:   return 8'($urandom);
        endcase
    endfunction

    // MAC addresses, VLAN tags, ethertype, layer-3 header, padding; cut > 0 truncates
    function automatic void build_frame(input t_frame_kind kind, input t_fill fill,
                                        input int tags, input int cut, input int extra);
        logic [15:0] et;
        int l3_len;
        frame_q.delete();
        if (kind == FK_RAW) begin
            for (int i = 0; i < cut; i++)
                frame_q.push_back(8'($urandom));
            return;
        end
        for (int i = 0; i < 12; i++)
            frame_q.push_back(fill_byte(fill));
        for (int t = 0; t < tags; t++) begin
            frame_q.push_back(ETH_VLAN[15:8]);
            frame_q.push_back(ETH_VLAN[7:0]);
            frame_q.push_back(fill_byte(fill));
            frame_q.push_back(fill_byte(fill));
        end
        case (kind)
            FK_IPV4: et = ETH_IPV4;
            FK_IPV6: et = ETH_IPV6;
            default: begin
                do et = 16'($urandom);
                while (et == ETH_IPV4 || et == ETH_IPV6 || et == ETH_VLAN);
            end
        endcase
        frame_q.push_back(et[15:8]);
        frame_q.push_back(et[7:0]);
        l3_len = (kind == FK_IPV6) ? 40 : 20;
        for (int i = 0; i < l3_len + extra; i++)
            frame_q.push_back(fill_byte(fill));
        if (cut > 0)
            while (frame_q.size() > cut)
                void'(frame_q.pop_back());
    endfunction

    // One byte beat; entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (!steady_send && burst_left == 0) begin
            gap = $urandom_range(1, 4);
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
            burst_left = $urandom_range(1, 48);
        end
        i_valid      = 1'b1;
        i_frame_byte = b;
        i_last_byte  = last;
        do @(posedge i_clk); while (o_stall);
        if (burst_left > 0)
            burst_left--;
        parse_byte(b);
        if (last) begin
            pending_flows.push_back(pin_flow ? pinned_flow : flow_result_now());
            clear_flow_state();
        end
        @(negedge i_clk);
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_q.size(); i++)
            send_byte(frame_q[i], i == frame_q.size() - 1);
    endtask

    // Let every result out and the back stage go quiet before touching registers
    task automatic settle();
        i_valid = 1'b0;
        while (pending_flows.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY_PAD) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_HASH_MODE)
            cfg_mode = data[MODE_W-1:0];
        else if (idx == CFG_SLAVE_COUNT)
            cfg_slaves = data;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            seen_flow = '{o_hash_value, o_slave_index, o_slave_mask};
            if (pending_flows.size() == 0) begin
                if (fault_count < REPORT_LIMIT)
                    $display("%0t: result with nothing pending: hash %h index %0d mask %h",
                             $realtime, o_hash_value, o_slave_index, o_slave_mask);
                fault_count++;
            end else begin
                head_flow = pending_flows.pop_front();
                if (seen_flow !== head_flow) begin
                    if (fault_count < REPORT_LIMIT)
                        $display({"%0t: mismatch hash exp %h got %h, index exp %0d got %0d,",
                                  " mask exp %h got %h"}, $realtime,
                                 head_flow.hash, seen_flow.hash, head_flow.idx, seen_flow.idx,
                                 head_flow.mask, seen_flow.mask);
                    fault_count++;
                end
            end
        end
    end

    // Receiver stall pattern, with one long hold-off on request
    initial begin : rx_side
        int hold_left;
        int style;
        int style_left;
        hold_left  = 0;
        style      = 0;
        style_left = 0;
        i_stall    = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                i_stall = 1'b1;
                hold_left--;
            end else begin
                if (style_left == 0) begin
                    style      = $urandom_range(0, 3);
                    style_left = $urandom_range(16, 96);
                end
                style_left--;
                case (style)
                    0: i_stall = 1'b0;
                    1: i_stall = ($urandom_range(0, 3) == 0);
                    2: i_stall = ($urandom_range(0, 3) != 0);
                    default: i_stall = ~i_stall;
                endcase
            end
        end
    end

    initial begin
        #20_000_000;
        $display("packet_flow_hash_distributor_test: done, errors");
        $finish;
    end

    initial begin : stim
        t_flow_case   row;
        logic [5:0]   corner_counts[7];
        logic [1:0]   new_mode;
        logic [3:0]   upper;
        logic [5:0]   cnt;
        t_frame_kind  kind;
        t_fill        fill;
        int           r;
        int           tags;
        int           cut;
        int           full_len;
        int           phase_no;
        int           frames_left;
        int           rand_bytes;
        int           rand_frames;
        bit           squeeze;

        corner_counts = '{6'd0, 6'd1, 6'd2, 6'd31, 6'd32, 6'd33, 6'd63};
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_frame_byte = '0;
        i_last_byte  = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CFG_HASH_MODE;
        i_cfg_data   = '0;
        fault_count  = 0;
        burst_left   = 0;
        steady_send  = 1'b0;
        hold_req     = 1'b0;
        pin_flow     = 1'b0;
        pinned_flow  = '0;
        clear_flow_state();

        // Directed frames; fixed results only where they follow directly
        dir_table.push_back('{MODE_IP, 6'd1, FK_RAW, FILL_RANDOM, 0, 1, 0, 1'b1,
                              '{32'h0, 5'd0, 32'h1}});
        dir_table.push_back('{MODE_IP, 6'd1, FK_IPV4, FILL_RANDOM, 0, 0, 3, 1'b0, '0});
        dir_table.push_back('{MODE_IP, 6'd1, FK_IPV6, FILL_RANDOM, 0, 0, 0, 1'b0, '0});
        dir_table.push_back('{MODE_IP, 6'd32, FK_IPV4, FILL_ONES, 0, 0, 0, 1'b1,
                              '{32'hFFFF_FFFE, 5'd30, 32'h4000_0000}});
        dir_table.push_back('{MODE_IP, 6'd32, FK_IPV6, FILL_ONES, 0, 0, 0, 1'b1,
                              '{32'hFFFF_FFF8, 5'd24, 32'h0100_0000}});
        dir_table.push_back('{MODE_IP, 6'd32, FK_IPV4, FILL_ZERO, 0, 0, 0, 1'b1,
                              '{32'h0, 5'd0, 32'h1}});
        dir_table.push_back('{MODE_IP, 6'd32, FK_IPV4, FILL_RANDOM, MAX_VLAN_TAGS, 0, 2,
                              1'b0, '0});
        // deep tag stack
        dir_table.push_back('{MODE_IP, 6'd32, FK_IPV4, FILL_RANDOM, MAX_VLAN_TAGS + 1, 0, 0,
                              1'b1, '{32'h0, 5'd0, 32'h1}});
        // unknown ethertype
        dir_table.push_back('{MODE_IP, 6'd32, FK_OTHER, FILL_RANDOM, 0, 0, 0, 1'b1,
                              '{32'h0, 5'd0, 32'h1}});
        // short frames: one byte short of the IPv4 / IPv6 header, and no ethertype
        dir_table.push_back('{MODE_IP, 6'd32, FK_IPV4, FILL_RANDOM, 0, 33, 0, 1'b1,
                              '{32'h0, 5'd0, 32'h1}});
        dir_table.push_back('{MODE_IP, 6'd32, FK_IPV6, FILL_RANDOM, 0, 53, 0, 1'b1,
                              '{32'h0, 5'd0, 32'h1}});
        dir_table.push_back('{MODE_IP, 6'd32, FK_RAW, FILL_RANDOM, 0, 13, 0, 1'b1,
                              '{32'h0, 5'd0, 32'h1}});
        dir_table.push_back('{MODE_MAC, 6'd32, FK_IPV4, FILL_ONES, 0, 0, 0, 1'b1,
                              '{32'd1530, 5'd26, 32'h0400_0000}});
        // only one MAC byte present
        dir_table.push_back('{MODE_MAC, 6'd32, FK_RAW, FILL_RANDOM, 0, 4, 0, 1'b0, '0});
        dir_table.push_back('{MODE_MAC, 6'd32, FK_IPV4, FILL_RANDOM, MAX_VLAN_TAGS + 1, 0, 0,
                              1'b0, '0});
        dir_table.push_back('{MODE_PROTO, 6'd32, FK_IPV4, FILL_RANDOM, 0, 0, 0, 1'b0, '0});
        dir_table.push_back('{MODE_PROTO, 6'd32, FK_IPV6, FILL_RANDOM, 2, 0, 5, 1'b0, '0});
        dir_table.push_back('{MODE_PROTO, 6'd32, FK_OTHER, FILL_RANDOM, 1, 0, 0, 1'b1,
                              '{32'h0, 5'd0, 32'h1}});
        // unused mode code acts as protocol mode
        dir_table.push_back('{MODE_SPARE, 6'd32, FK_IPV4, FILL_ONES, 0, 0, 0, 1'b1,
                              '{32'd255, 5'd31, 32'h8000_0000}});
        dir_table.push_back('{MODE_SPARE, 6'd32, FK_IPV6, FILL_RANDOM, 0, 0, 0, 1'b0, '0});
        // slave count zero and above the limit
        dir_table.push_back('{MODE_IP, 6'd0, FK_IPV4, FILL_ONES, 0, 0, 0, 1'b1,
                              '{32'hFFFF_FFFE, 5'd0, 32'h1}});
        dir_table.push_back('{MODE_IP, 6'd63, FK_IPV4, FILL_ONES, 0, 0, 0, 1'b1,
                              '{32'hFFFF_FFFE, 5'd30, 32'h4000_0000}});
        dir_table.push_back('{MODE_IP, 6'd33, FK_IPV6, FILL_RANDOM, 1, 0, 0, 1'b0, '0});
        dir_table.push_back('{MODE_IP, 6'd7, FK_IPV4, FILL_RANDOM, 0, 0, 0, 1'b0, '0});

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int k = 0; k < dir_table.size(); k++) begin
            row = dir_table[k];
            if (row.mode != cfg_mode || row.count != cfg_slaves) begin
                settle();
                if (row.mode != cfg_mode)
                    write_reg(CFG_HASH_MODE, {{(CNT_W-MODE_W){1'b0}}, row.mode});
                if (row.count != cfg_slaves)
                    write_reg(CFG_SLAVE_COUNT, row.count);
            end
            pin_flow    = row.pinned;
            pinned_flow = row.want;
            build_frame(row.kind, row.fill, row.tags, row.cut, row.extra);
            send_frame();
        end
        pin_flow = 1'b0;

        // Random phases, each with its own register settings
        phase_no    = 0;
        frames_left = 0;
        rand_bytes  = 0;
        rand_frames = 0;
        squeeze     = 1'b0;
        while (rand_bytes < RAND_BYTES || rand_frames < RAND_FRAMES) begin
            if (frames_left == 0) begin
                settle();
                new_mode = $urandom_range(0, 3);
                upper    = $urandom_range(0, 15);
                write_reg(CFG_HASH_MODE, {upper, new_mode});
                case ($urandom_range(0, 3))
                    0: cnt = corner_counts[$urandom_range(0, 6)];
                    1: cnt = $urandom_range(0, 63);
                    default: cnt = $urandom_range(1, 32);
                endcase
                write_reg(CFG_SLAVE_COUNT, cnt);
                if (phase_no == 1) begin
                    write_reg(CFG_SPARE_LO, 6'($urandom));
                    write_reg(CFG_SPARE_HI, 6'($urandom));
                end
                steady_send = ($urandom_range(0, 3) == 0);
                frames_left = $urandom_range(6, 14);
                squeeze     = 1'b0;
                // long receiver hold-off against a stream of tiny frames
                if (phase_no == 0) begin
                    steady_send = 1'b1;
                    squeeze     = 1'b1;
                    frames_left = 12;
                    hold_req    = 1'b1;
                end
                phase_no++;
            end

            r     = $urandom_range(0, 99);
            tags  = ($urandom_range(0, 9) == 0) ? $urandom_range(MAX_VLAN_TAGS, MAX_VLAN_TAGS + 2)
                                                : $urandom_range(0, 2);
            case ($urandom_range(0, 19))
                0: fill = FILL_ZERO;
                1: fill = FILL_ONES;
                default: fill = FILL_RANDOM;
            endcase
            cut = 0;
            if (squeeze) begin
                kind = FK_RAW;
                cut  = $urandom_range(1, 6);
            end else if (r < 38) begin
                kind = FK_IPV4;
            end else if (r < 70) begin
                kind = FK_IPV6;
            end else if (r < 78) begin
                kind = FK_OTHER;
            end else if (r < 88) begin
                kind = FK_RAW;
                cut  = $urandom_range(1, 40);
            end else begin
                // truncated inside the headers
                kind     = ($urandom_range(0, 1) == 0) ? FK_IPV4 : FK_IPV6;
                full_len = 14 + 4 * tags + ((kind == FK_IPV6) ? 40 : 20);
                cut      = $urandom_range(1, full_len - 1);
            end
            build_frame(kind, fill, tags, cut, $urandom_range(0, 12));
            send_frame();
            rand_bytes += frame_q.size();
            rand_frames++;
            frames_left--;
        end

        i_valid = 1'b0;
        while (pending_flows.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY_PAD) @(posedge i_clk);
        if (fault_count == 0 && pending_flows.size() == 0)
            $display("packet_flow_hash_distributor_test: done, clean");
        else
            $display("packet_flow_hash_distributor_test: done, errors");
        $finish;
    end

endmodule
